// ===== src/fbcm_pkg.sv =====
// Shared types, constants and the constant-divisor helper of the floppy block mapper.
`default_nettype none

package fbcm_pkg;

  // Disk geometry
  localparam int unsigned SECTORS_PER_TRACK = 10;
  localparam int unsigned TRACKS_PER_SIDE   = 80;

  // Field widths
  localparam int unsigned BLOCK_W  = 12;
  localparam int unsigned MINOR_W  = 4;
  localparam int unsigned TRACK_W  = 7;
  localparam int unsigned SECTOR_W = 4;
  localparam int unsigned CMD_W    = 7;

  localparam int unsigned BLOCK_MAX = (2 ** BLOCK_W) - 1;

  // Internal widths of quotients and remainders
  localparam int unsigned QS_W  = $clog2(BLOCK_MAX / SECTORS_PER_TRACK + 2);
  localparam int unsigned Q2S_W = $clog2(BLOCK_MAX / (2 * SECTORS_PER_TRACK) + 2);
  localparam int unsigned QST_W =
    $clog2(BLOCK_MAX / (SECTORS_PER_TRACK * TRACKS_PER_SIDE) + 2);
  localparam int unsigned RS_W  = $clog2(SECTORS_PER_TRACK);
  localparam int unsigned R2S_W = $clog2(2 * SECTORS_PER_TRACK);

  // Action codes
  localparam logic [1:0] ACT_NEW     = 2'd0;
  localparam logic [1:0] ACT_REPEAT  = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;

  // Layout modes, minor bits 2..0
  localparam logic [2:0] MODE_SKEW3          = 3'd0;
  localparam logic [2:0] MODE_PLAIN          = 3'd1;
  localparam logic [2:0] MODE_INTERLEAVE     = 3'd2;
  localparam logic [2:0] MODE_RESERVED       = 3'd3;
  localparam logic [2:0] MODE_DS_SPLIT       = 3'd4;
  localparam logic [2:0] MODE_DS_ALT         = 3'd5;
  localparam logic [2:0] MODE_INTERLEAVE_UP  = 3'd6;
  localparam logic [2:0] MODE_DS_SKEW3       = 3'd7;

  // Controller command bases
  localparam logic [CMD_W-1:0] CMD_READ  = 7'o110;
  localparam logic [CMD_W-1:0] CMD_WRITE = 7'o170;

  // Reciprocal division: quotient estimate is at most one low, fixed by one compare
  localparam int unsigned DIV_W     = 16;
  localparam int unsigned DIV_SHIFT = 17;
  localparam logic [DIV_SHIFT-1:0] RECIP_S   =
    DIV_SHIFT'((2 ** DIV_SHIFT) / SECTORS_PER_TRACK);
  localparam logic [DIV_SHIFT-1:0] RECIP_2S  =
    DIV_SHIFT'((2 ** DIV_SHIFT) / (2 * SECTORS_PER_TRACK));
  localparam logic [DIV_SHIFT-1:0] RECIP_ST  =
    DIV_SHIFT'((2 ** DIV_SHIFT) / (SECTORS_PER_TRACK * TRACKS_PER_SIDE));

  typedef struct packed {
    logic [1:0]         action;
    logic [BLOCK_W-1:0] block_number;
    logic [MINOR_W-1:0] device_minor;
    logic               is_read;
  } fbcm_req_t;

  typedef struct packed {
    logic [TRACK_W-1:0]  track;
    logic [SECTOR_W-1:0] sector;
    logic                side;
    logic [CMD_W-1:0]    command_word;
    logic                invalid;
  } fbcm_rsp_t;

  typedef struct packed {
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } fbcm_divmod_t;

  // Divide by a build-time constant through its scaled reciprocal
  function automatic fbcm_divmod_t div_const(input logic [DIV_W-1:0]     value,
                                             input logic [DIV_W-1:0]     divisor,
                                             input logic [DIV_SHIFT-1:0] recip);
    logic [DIV_W+DIV_SHIFT-1:0] prod;
    logic [DIV_W-1:0]           quot;
    logic [DIV_W-1:0]           rem;
    fbcm_divmod_t               res;
    prod = (DIV_W + DIV_SHIFT)'(value) * (DIV_W + DIV_SHIFT)'(recip);
    quot = prod[DIV_SHIFT +: DIV_W];
    rem  = value - DIV_W'((2 * DIV_W)'(quot) * (2 * DIV_W)'(divisor));
    if (rem >= divisor) begin
      quot = quot + 1'b1;
      rem  = rem - divisor;
    end
    res.quot = quot;
    res.rem  = rem;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/floppy_block_to_chs_mapper_core.sv =====
// Top level of the floppy block to track/sector/side mapper with command word.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+--------------------------
//  request  | in        | in_valid_i / in_stall_o | in_req_i  (fbcm_req_t)
//  result   | out       | out_valid_o/ out_stall_i| out_rsp_o (fbcm_rsp_t)
//
//  One request per cycle sustained while the result is not stalled. A request
//  passes state, divide and map stages, one register each; out_valid_o shows
//  its result from the map stage. The reciprocal divides set the stage split.
//  Reset clears the stored block, mode and read flag (block 0, mode 0, write)
//  and empties all stages; no memory needs clearing.
//  in_stall_o rises only when all three stages hold requests and the result
//  is stalled; any empty stage keeps the request side flowing.
`default_nettype none

module floppy_block_to_chs_mapper_core
  import fbcm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire fbcm_req_t in_req_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output fbcm_rsp_t      out_rsp_o
);

  // Divide stage payload
  typedef struct packed {
    logic [QS_W-1:0]    q_s;
    logic [RS_W-1:0]    r_s;
    logic [Q2S_W-1:0]   q_2s;
    logic [R2S_W-1:0]   r_2s;
    logic [QST_W-1:0]   q_st;
    logic [RS_W-1:0]    r3_s;
    logic [R2S_W-1:0]   r3_2s;
    logic [MINOR_W-1:0] minor;
    logic               is_read;
    logic               invalid;
  } fbcm_mid_t;

  // Advance a track by one, wrapping the last track to zero
  function automatic logic [QS_W-1:0] rotate_track(input logic [QS_W-1:0] t);
    logic [QS_W-1:0] n;
    n = t + 1'b1;
    if (n == QS_W'(TRACKS_PER_SIDE)) begin
      n = '0;
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------
  // Stage handshake: each stage moves when the one after it can take
  // ---------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  logic out_valid_q, out_valid_d;
  logic s2_ready, s3_ready;
  logic in_accept, s2_take, s3_take;

  assign s3_ready   = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s2_take    = s1_valid_q && s2_ready;
  assign s3_take    = s2_valid_q && s3_ready;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s2_valid_d  = s2_valid_q;
    out_valid_d = out_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s2_take) begin
      s1_valid_d = 1'b0;
    end
    if (s2_take) begin
      s2_valid_d = 1'b1;
    end else if (s3_take) begin
      s2_valid_d = 1'b0;
    end
    if (s3_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // State stage: stored block, minor and read flag double as stage payload
  // ---------------------------------------------------------------------
  logic [BLOCK_W-1:0] block_q, block_d;
  logic [MINOR_W-1:0] minor_q, minor_d;
  logic               read_q, read_d;
  logic               s1_invalid_q, s1_invalid_d;
  logic               range_bad;

  // Double-sided layouts (minor bit 2) allow twice the blocks
  assign range_bad = in_req_i.device_minor[2]
    ? ((BLOCK_W + 1)'(in_req_i.block_number) >=
       (BLOCK_W + 1)'(2 * SECTORS_PER_TRACK * TRACKS_PER_SIDE))
    : ((BLOCK_W + 1)'(in_req_i.block_number) >=
       (BLOCK_W + 1)'(SECTORS_PER_TRACK * TRACKS_PER_SIDE));

  always_comb begin
    block_d      = block_q;
    minor_d      = minor_q;
    read_d       = read_q;
    s1_invalid_d = s1_invalid_q;
    if (in_accept) begin
      s1_invalid_d = 1'b0;
      case (in_req_i.action)
        ACT_NEW: begin
          // Drop a bad request without touching the stored state
          if (range_bad) begin
            s1_invalid_d = 1'b1;
          end else begin
            block_d = in_req_i.block_number;
            minor_d = in_req_i.device_minor;
            read_d  = in_req_i.is_read;
          end
        end
        ACT_ADVANCE: begin
          block_d = block_q + 1'b1;
        end
        default: begin
          // Repeat, and the unused code, hold the stored block
          block_d = block_q;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Divide stage: all quotients and remainders of the stored block
  // ---------------------------------------------------------------------
  fbcm_mid_t    mid_q, mid_d;
  fbcm_divmod_t dm_s, dm_2s, dm_st;
  logic [RS_W+1:0]  x3_s;
  logic [R2S_W+1:0] x3_2s;

  always_comb begin
    dm_s  = div_const(DIV_W'(block_q), DIV_W'(SECTORS_PER_TRACK), RECIP_S);
    dm_2s = div_const(DIV_W'(block_q), DIV_W'(2 * SECTORS_PER_TRACK), RECIP_2S);
    dm_st = div_const(DIV_W'(block_q),
                      DIV_W'(SECTORS_PER_TRACK * TRACKS_PER_SIDE), RECIP_ST);

    // 3b mod S from b mod S: the triple stays below 3S
    x3_s = (RS_W + 2)'(dm_s.rem[RS_W-1:0]) * (RS_W + 2)'(3);
    if (x3_s >= (RS_W + 2)'(2 * SECTORS_PER_TRACK)) begin
      x3_s = x3_s - (RS_W + 2)'(2 * SECTORS_PER_TRACK);
    end else if (x3_s >= (RS_W + 2)'(SECTORS_PER_TRACK)) begin
      x3_s = x3_s - (RS_W + 2)'(SECTORS_PER_TRACK);
    end

    // 3b mod 2S from b mod 2S: the triple stays below 6S
    x3_2s = (R2S_W + 2)'(dm_2s.rem[R2S_W-1:0]) * (R2S_W + 2)'(3);
    if (x3_2s >= (R2S_W + 2)'(4 * SECTORS_PER_TRACK)) begin
      x3_2s = x3_2s - (R2S_W + 2)'(4 * SECTORS_PER_TRACK);
    end else if (x3_2s >= (R2S_W + 2)'(2 * SECTORS_PER_TRACK)) begin
      x3_2s = x3_2s - (R2S_W + 2)'(2 * SECTORS_PER_TRACK);
    end

    mid_d.q_s     = dm_s.quot[QS_W-1:0];
    mid_d.r_s     = dm_s.rem[RS_W-1:0];
    mid_d.q_2s    = dm_2s.quot[Q2S_W-1:0];
    mid_d.r_2s    = dm_2s.rem[R2S_W-1:0];
    mid_d.q_st    = dm_st.quot[QST_W-1:0];
    mid_d.r3_s    = x3_s[RS_W-1:0];
    mid_d.r3_2s   = x3_2s[R2S_W-1:0];
    mid_d.minor   = minor_q;
    mid_d.is_read = read_q;
    mid_d.invalid = s1_invalid_q;
  end

  // ---------------------------------------------------------------------
  // Map stage: pick the layout and form the command word
  // ---------------------------------------------------------------------
  fbcm_rsp_t       rsp_d, rsp_q;
  fbcm_divmod_t    dm_il;
  logic [QS_W-1:0] trk;
  logic [RS_W-1:0] sec;
  logic [RS_W:0]   sec_p1;
  logic [RS_W:0]   s_il;
  logic [QS_W-1:0] t_base;
  logic [QS_W-1:0] t_mod;
  logic            sd;

  always_comb begin
    // Interleaved layouts: doubled sector, folded back, skewed by two per track
    s_il = {mid_q.r_s, 1'b0};
    if (s_il >= (RS_W + 1)'(SECTORS_PER_TRACK)) begin
      s_il = s_il - (RS_W + 1)'(SECTORS_PER_TRACK - 1);
    end
    dm_il = div_const(DIV_W'(s_il) + DIV_W'({mid_q.q_s, 1'b0}),
                      DIV_W'(SECTORS_PER_TRACK), RECIP_S);

    // Track within its side for the split double-sided layout
    t_base = QS_W'(QS_W'(mid_q.q_st) * QS_W'(TRACKS_PER_SIDE));
    t_mod  = mid_q.q_s - t_base;

    trk = '0;
    sec = '0;
    sd  = 1'b0;
    unique case (mid_q.minor[2:0]) inside
      MODE_SKEW3: begin
        sec = mid_q.r3_s;
        trk = rotate_track(mid_q.q_s);
      end
      MODE_PLAIN: begin
        sec = mid_q.r_s;
        trk = mid_q.q_s;
      end
      MODE_INTERLEAVE, MODE_INTERLEAVE_UP: begin
        sec = dm_il.rem[RS_W-1:0];
        trk = rotate_track(mid_q.q_s);
        sd  = (mid_q.minor[2:0] == MODE_INTERLEAVE_UP);
      end
      MODE_RESERVED: begin
        sec = RS_W'(1);
        trk = QS_W'(1);
      end
      MODE_DS_SPLIT: begin
        sec = mid_q.r3_s;
        sd  = (mid_q.q_s >= QS_W'(TRACKS_PER_SIDE));
        trk = rotate_track(t_mod);
      end
      MODE_DS_ALT: begin
        sec = mid_q.r_s;
        trk = QS_W'(mid_q.q_2s);
        sd  = (mid_q.r_2s >= R2S_W'(SECTORS_PER_TRACK));
      end
      MODE_DS_SKEW3: begin
        sec = mid_q.r3_s;
        trk = rotate_track(QS_W'(mid_q.q_2s));
        sd  = (mid_q.r3_2s >= R2S_W'(SECTORS_PER_TRACK));
      end
    endcase

    sec_p1 = {1'b0, sec} + 1'b1;

    if (mid_q.invalid) begin
      rsp_d         = '0;
      rsp_d.invalid = 1'b1;
    end else begin
      rsp_d.track        = TRACK_W'(trk);
      rsp_d.sector       = SECTOR_W'(sec_p1);
      rsp_d.side         = sd;
      rsp_d.command_word = (mid_q.is_read ? CMD_READ : CMD_WRITE) |
                           CMD_W'({mid_q.minor[3], sd});
      rsp_d.invalid      = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      block_q      <= '0;
      minor_q      <= '0;
      read_q       <= 1'b0;
      s1_invalid_q <= 1'b0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      s2_valid_q   <= s2_valid_d;
      out_valid_q  <= out_valid_d;
      block_q      <= block_d;
      minor_q      <= minor_d;
      read_q       <= read_d;
      s1_invalid_q <= s1_invalid_d;
    end
  end

  // Payload stages carry no reset
  always_ff @(posedge clk_i) begin
    if (s2_take) begin
      mid_q <= mid_d;
    end
    if (s3_take) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

// ===== src/fbcm_checker.sv =====
// Port-level checker of the floppy block mapper and its bind to the top level.
`default_nettype none

module fbcm_checker
  import fbcm_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire fbcm_req_t in_req_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire fbcm_rsp_t out_rsp_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed or vanished");

  // A rejected request carries zero fields
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.invalid |->
      out_rsp_o.track == '0 && out_rsp_o.sector == '0 &&
      !out_rsp_o.side && out_rsp_o.command_word == '0)
    else $error("invalid result with nonzero fields");

  // A mapped result has a one-based sector and a well-formed command word
  a_mapped_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.invalid |->
      out_rsp_o.sector != '0 && out_rsp_o.command_word[6] &&
      out_rsp_o.command_word[3] && out_rsp_o.command_word[0] == out_rsp_o.side)
    else $error("malformed mapped result");

  // Back-pressure only passes through from a stalled result
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request side stalled while result side is free");

endmodule

bind floppy_block_to_chs_mapper_core fbcm_checker u_fbcm_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench of the floppy block to track/sector/side mapper core.
module testbench
  import fbcm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SPT = SECTORS_PER_TRACK;
  localparam int unsigned TPS = TRACKS_PER_SIDE;

  // Action 3 has no name in the package; the block treats it as a repeat
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Density bit of the minor lands here in the command word
  localparam logic [CMD_W-1:0] CMD_DENSITY = 7'o002;

  localparam int unsigned MAX_CYCLES      = 1_000_000;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned BURST_REQS      = 30;
  localparam int unsigned WRAP_ADVANCES   = 160;
  localparam int unsigned PHASE_REQS      = 150;
  localparam int unsigned NUM_PHASES      = 4;
  localparam int unsigned MAX_REPORTS     = 40;
  localparam int unsigned NUM_DIRECTED    = 24;

  localparam fbcm_rsp_t NO_RSP = '0;

  typedef struct packed {
    fbcm_req_t rq;
    logic      typed;
    fbcm_rsp_t rsp;
  } directed_row_t;

  // Directed requests; rows with typed set carry a hand-written result
  directed_row_t directed_reqs [NUM_DIRECTED] = '{
    // after reset: block 0, mode 0, write
    '{'{ACT_REPEAT,  12'd0,    4'd0,  1'b0}, 1'b1, '{7'd1, 4'd1, 1'b0, CMD_WRITE, 1'b0}},
    '{'{ACT_ADVANCE, 12'd4095, 4'd15, 1'b1}, 1'b0, NO_RSP},
    // out of range new requests
    '{'{ACT_NEW,     12'd4095, 4'd0,  1'b1}, 1'b1, '{7'd0, 4'd0, 1'b0, 7'd0, 1'b1}},
    '{'{ACT_NEW,     12'd800,  4'd0,  1'b0}, 1'b1, '{7'd0, 4'd0, 1'b0, 7'd0, 1'b1}},
    '{'{ACT_NEW,     12'd1600, 4'd4,  1'b1}, 1'b1, '{7'd0, 4'd0, 1'b0, 7'd0, 1'b1}},
    '{'{ACT_NEW,     12'd1600, 4'd12, 1'b0}, 1'b1, '{7'd0, 4'd0, 1'b0, 7'd0, 1'b1}},
    // reserved layout gives fixed values
    '{'{ACT_NEW,     12'd0,    4'd3,  1'b1}, 1'b1, '{7'd1, 4'd2, 1'b0, CMD_READ, 1'b0}},
    '{'{ACT_NEW,     12'd0,    4'd11, 1'b0}, 1'b1,
      '{7'd1, 4'd2, 1'b0, CMD_WRITE | CMD_DENSITY, 1'b0}},
    // last block of each layout; in the rotating layouts the track wraps to zero
    '{'{ACT_NEW,     12'd799,  4'd0,  1'b1}, 1'b0, NO_RSP},
    '{'{ACT_NEW,     12'd799,  4'd1,  1'b0}, 1'b0, NO_RSP},
    '{'{ACT_NEW,     12'd799,  4'd2,  1'b1}, 1'b0, NO_RSP},
    '{'{ACT_NEW,     12'd799,  4'd6,  1'b0}, 1'b0, NO_RSP},
    '{'{ACT_NEW,     12'd1599, 4'd4,  1'b1}, 1'b0, NO_RSP},
    '{'{ACT_NEW,     12'd1599, 4'd5,  1'b0}, 1'b0, NO_RSP},
    '{'{ACT_NEW,     12'd1599, 4'd7,  1'b1}, 1'b0, NO_RSP},
    '{'{ACT_NEW,     12'd1599, 4'd15, 1'b0}, 1'b0, NO_RSP},
    // step past the end of the disk, then repeat it both ways
    '{'{ACT_ADVANCE, 12'd0,    4'd0,  1'b0}, 1'b0, NO_RSP},
    '{'{ACT_REPEAT,  12'd4095, 4'd15, 1'b1}, 1'b0, NO_RSP},
    '{'{ACT_UNUSED,  12'd2730, 4'd10, 1'b1}, 1'b0, NO_RSP},
    '{'{ACT_NEW,     12'd0,    4'd1,  1'b1}, 1'b0, NO_RSP},
    '{'{ACT_ADVANCE, 12'd1365, 4'd5,  1'b0}, 1'b0, NO_RSP},
    '{'{ACT_NEW,     12'd13,   4'd9,  1'b0}, 1'b0, NO_RSP},
    '{'{ACT_NEW,     12'd1234, 4'd13, 1'b1}, 1'b0, NO_RSP},
    '{'{ACT_NEW,     12'd0,    4'd0,  1'b0}, 1'b0, NO_RSP}
  };

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  fbcm_req_t in_req_i    = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  fbcm_rsp_t out_rsp_o;

  // Predictor copy of the stored request
  logic [BLOCK_W-1:0] cur_block = '0;
  logic [MINOR_W-1:0] cur_minor = '0;
  logic               cur_read  = 1'b0;

  // Results the block still owes, oldest first
  fbcm_rsp_t   pending_rsp_q [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  // Bumped by the sender to ask the receiver for one long hold-off
  int unsigned hold_off_reqs = 0;
  int unsigned hold_off_seen = 0;

  floppy_block_to_chs_mapper_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned next_track(input int unsigned t);
    // Rotate by one track; the last track folds back to zero
    return (t + 1 == TPS) ? 0 : t + 1;
  endfunction

  // Work out the result of one request and advance the stored state
  function automatic fbcm_rsp_t map_request(input fbcm_req_t rq);
    int unsigned lim;
    int unsigned b;
    int unsigned t;
    int unsigned s;
    int unsigned trk;
    int unsigned sec;
    int unsigned sd;
    fbcm_rsp_t   rsp;
    rsp = '0;
    if (rq.action == ACT_NEW) begin
      lim = rq.device_minor[2] ? 2 * SPT * TPS : SPT * TPS;
      // Reject and load nothing when the block is past the disk
      if (rq.block_number >= lim) begin
        rsp.invalid = 1'b1;
        return rsp;
      end
      cur_block = rq.block_number;
      cur_minor = rq.device_minor;
      cur_read  = rq.is_read;
    end else if (rq.action == ACT_ADVANCE) begin
      cur_block = cur_block + 1'b1;
    end
    b  = cur_block;
    sd = 0;
    case (cur_minor[2:0])
      MODE_SKEW3: begin
        sec = (3 * b) % SPT;
        trk = next_track(b / SPT);
      end
      MODE_PLAIN: begin
        sec = b % SPT;
        trk = b / SPT;
      end
      MODE_INTERLEAVE, MODE_INTERLEAVE_UP: begin
        t = b / SPT;
        s = 2 * (b % SPT);
        if (s >= SPT) s = s - (SPT - 1);
        sec = (s + 2 * t) % SPT;
        trk = next_track(t);
        sd  = (cur_minor[2:0] == MODE_INTERLEAVE_UP);
      end
      MODE_DS_SPLIT: begin
        t   = b / SPT;
        sec = (3 * b) % SPT;
        sd  = (t >= TPS);
        trk = next_track(t % TPS);
      end
      MODE_DS_ALT: begin
        sec = b % SPT;
        trk = b / (2 * SPT);
        sd  = ((b % (2 * SPT)) >= SPT);
      end
      MODE_DS_SKEW3: begin
        sec = (3 * b) % SPT;
        trk = next_track(b / (2 * SPT));
        sd  = (((3 * b) % (2 * SPT)) >= SPT);
      end
      default: begin
        trk = 1;
        sec = 1;
      end
    endcase
    rsp.track        = TRACK_W'(trk);
    rsp.sector       = SECTOR_W'(sec + 1);
    rsp.side         = sd[0];
    rsp.command_word = (cur_read ? CMD_READ : CMD_WRITE) | {cur_minor[3], 1'b0} | CMD_W'(sd);
    return rsp;
  endfunction

  // Mostly well-formed: new requests mostly in range, plus repeats, advances and the unused action
  function automatic fbcm_req_t random_request();
    fbcm_req_t   rq;
    int unsigned pick;
    int unsigned lim;
    pick            = $urandom_range(0, 99);
    rq.block_number = BLOCK_W'($urandom_range(0, BLOCK_MAX));
    rq.device_minor = MINOR_W'($urandom_range(0, 15));
    rq.is_read      = 1'($urandom_range(0, 1));
    if (pick < 30) begin
      rq.action = ACT_NEW;
      lim = rq.device_minor[2] ? 2 * SPT * TPS : SPT * TPS;
      if ($urandom_range(0, 9) < 8) rq.block_number = BLOCK_W'($urandom_range(0, lim - 1));
    end else if (pick < 60) begin
      rq.action = ACT_REPEAT;
    end else if (pick < 95) begin
      rq.action = ACT_ADVANCE;
    end else begin
      rq.action = ACT_UNUSED;
    end
    return rq;
  endfunction

  // Gap after a request: none when steady, else mostly none or short, now and then long
  function automatic int unsigned pick_gap(input logic steady);
    int unsigned pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request, hold it until accepted, then log what it must produce
  task automatic send_request(input fbcm_req_t rq, input logic typed,
                              input fbcm_rsp_t typed_rsp);
    fbcm_rsp_t want;
    in_valid_i <= 1'b1;
    in_req_i   <= rq;
    do @(posedge clk_i); while (in_stall_o);
    want = map_request(rq);
    pending_rsp_q.push_back(typed ? typed_rsp : want);
  endtask

  task automatic idle(input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold until every owed result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input fbcm_rsp_t got);
    fbcm_rsp_t want;
    if (pending_rsp_q.size() == 0) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = pending_rsp_q.pop_front();
    check_field("track", want.track, got.track);
    check_field("sector", want.sector, got.sector);
    check_field("side", want.side, got.side);
    check_field("command_word", want.command_word, got.command_word);
    check_field("invalid", want.invalid, got.invalid);
  endtask

  // Result side: check each accepted result, then pick the next stall level
  initial begin
    int unsigned stall_left;
    int unsigned flow_left;
    int unsigned pick;
    stall_left = 0;
    flow_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_result(out_rsp_o);
      if (hold_off_reqs != hold_off_seen) begin
        // Long hold-off so the pipe fills and the request side stalls
        hold_off_seen = hold_off_reqs;
        stall_left    = HOLD_OFF_CYCLES;
        flow_left     = 0;
      end else if (stall_left == 0 && flow_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) flow_left = $urandom_range(1, 8);
        else if (pick < 60) flow_left = $urandom_range(30, 80);
        else if (pick < 92) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(10, 40);
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (flow_left != 0) flow_left--;
      end
    end
  end

  // Watchdog: give up well beyond the slowest correct run
  initial begin
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Request side: reset, directed table, run past the disk end, random phases
  initial begin
    fbcm_req_t   rq;
    int unsigned n;
    int unsigned phase;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_reqs[i]) begin
      send_request(directed_reqs[i].rq, directed_reqs[i].typed, directed_reqs[i].rsp);
      idle(pick_gap(1'b0));
    end
    drain();

    // Load the last double-sided block, then step on past the end of the disk
    rq              = random_request();
    rq.action       = ACT_NEW;
    rq.block_number = BLOCK_W'(2 * SPT * TPS - 1);
    rq.device_minor = rq.device_minor | MINOR_W'(4);
    send_request(rq, 1'b0, NO_RSP);
    for (n = 0; n < WRAP_ADVANCES; n++) begin
      rq        = random_request();
      rq.action = ACT_ADVANCE;
      send_request(rq, 1'b0, NO_RSP);
      idle(pick_gap(1'b0));
    end
    drain();

    // Phase 1 runs back to back; phase 2 opens with a burst into a hold-off
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 2) hold_off_reqs <= hold_off_reqs + 1;
      for (n = 0; n < PHASE_REQS; n++) begin
        send_request(random_request(), 1'b0, NO_RSP);
        idle(pick_gap(phase == 1 || (phase == 2 && n < BURST_REQS)));
      end
      drain();
    end

    // Watch a little longer for stray results
    repeat (2 * DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fbcm_pkg.sv
src/floppy_block_to_chs_mapper_core.sv
src/fbcm_checker.sv
tb/testbench.sv
